// ===== src/midpoint_circle_rasterizer_top_defines.svh =====
// Assertion macros for the midpoint circle rasterizer checker.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mcr_pkg.sv =====
// Shared types and constants for the midpoint circle rasterizer.
package mcr_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 16;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 12;
  localparam int COLOR_W   = 24;
  localparam int NCAND     = 8;

  localparam logic [CFG_W-1:0] CANVAS_W_RESET = 13'd800;
  localparam logic [CFG_W-1:0] CANVAS_H_RESET = 13'd600;
  localparam logic [CFG_W-1:0] CANVAS_MAX     = 13'd4096;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  // Per-step control flags handed from the state unit to the evaluator.
  typedef struct packed {
    logic inactive;
    logic zero_radius;
    logic filled;
    logic mirror_en;
    logic diag_en;
    logic done;
  } step_flags_t;

  // One candidate pixel or span.
  typedef struct packed {
    logic [OUT_W-1:0] x;
    logic [OUT_W-1:0] xe;
    logic [OUT_W-1:0] y;
    logic             vis;
  } cand_t;

endpackage

// ===== src/mcr_state.sv =====
// Canvas registers, circle state, decision loop update and the step input register.
module mcr_state #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [COORD_BITS-1:0]    in_center_x,
  input  logic signed [COORD_BITS-1:0]    in_center_y,
  input  logic [RADIUS_BITS-1:0]          in_radius,
  input  logic                            in_fill_mode,
  input  logic [mcr_pkg::COLOR_W-1:0]     in_color_in,
  input  logic                            a_take,
  output logic                            a_valid,
  output logic signed [COORD_BITS-1:0]    a_cx,
  output logic signed [COORD_BITS-1:0]    a_cy,
  output logic [RADIUS_BITS:0]            a_x,
  output logic [RADIUS_BITS:0]            a_y,
  output logic [mcr_pkg::COLOR_W-1:0]     a_color,
  output mcr_pkg::step_flags_t            a_flags,
  output logic [mcr_pkg::CFG_W-1:0]       canvas_w,
  output logic [mcr_pkg::CFG_W-1:0]       canvas_h
);

  localparam int OW = RADIUS_BITS + 1;
  localparam int DW = RADIUS_BITS + 3;

  logic [mcr_pkg::CFG_W-1:0]   width_r, height_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [OW-1:0]               maj_r, min_r;
  logic signed [DW-1:0]        dec_r;
  logic                        filled_r, active_r;
  logic [mcr_pkg::COLOR_W-1:0] color_r;

  logic signed [COORD_BITS-1:0] a_cx_r, a_cy_r;
  logic [OW-1:0]               a_x_r, a_y_r;
  logic [mcr_pkg::COLOR_W-1:0] a_color_r;
  mcr_pkg::step_flags_t        a_flags_r;
  logic                        a_valid_r;

  logic                        accept, zero_rad;
  logic [OW-1:0]               y_nxt, x_dec, x_nxt;
  logic signed [DW-1:0]        diff, dec_nxt;
  mcr_pkg::step_flags_t        flags_nxt;

  assign in_ready = !a_valid_r || a_take;
  assign accept   = in_valid && in_ready;

  assign canvas_w = (width_r  > mcr_pkg::CANVAS_MAX) ? mcr_pkg::CANVAS_MAX : width_r;
  assign canvas_h = (height_r > mcr_pkg::CANVAS_MAX) ? mcr_pkg::CANVAS_MAX : height_r;

  // One iteration of the midpoint decision loop.
  always_comb begin
    y_nxt    = min_r + OW'(1);
    x_dec    = maj_r - OW'(1);
    zero_rad = (maj_r == '0) && (min_r == '0);
    diff     = $signed(DW'(y_nxt)) - $signed(DW'(x_dec));
    if (dec_r <= $signed(DW'(0))) begin
      x_nxt   = maj_r;
      dec_nxt = dec_r + $signed(DW'({y_nxt, 1'b1}));
    end else begin
      x_nxt   = x_dec;
      dec_nxt = dec_r + (diff <<< 1) + $signed(DW'(1));
    end
    flags_nxt.inactive    = !active_r;
    flags_nxt.zero_radius = zero_rad;
    flags_nxt.filled      = filled_r;
    flags_nxt.mirror_en   = (min_r != '0);
    flags_nxt.diag_en     = (maj_r != min_r);
    flags_nxt.done        = !active_r || zero_rad || (x_nxt < y_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= mcr_pkg::CANVAS_W_RESET;
      height_r  <= mcr_pkg::CANVAS_H_RESET;
      active_r  <= 1'b0;
      a_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mcr_pkg::REG_CANVAS_WIDTH:  width_r  <= cfg_data;
          mcr_pkg::REG_CANVAS_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (a_take) begin
        a_valid_r <= 1'b0;
      end
      if (accept) begin
        if (in_cmd == mcr_pkg::CMD_LOAD) begin
          active_r <= 1'b1;
        end else begin
          a_valid_r <= 1'b1;
          if (active_r) begin
            active_r <= !(zero_rad || (x_nxt < y_nxt));
          end
        end
      end
    end
  end

  // The circle state resets to zero, so a step before any load reports a black colour.
  // The step snapshot carries no reset; a_valid_r qualifies it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      maj_r    <= '0;
      min_r    <= '0;
      dec_r    <= '0;
      filled_r <= 1'b0;
      color_r  <= '0;
    end else if (accept) begin
      if (in_cmd == mcr_pkg::CMD_LOAD) begin
        cx_r     <= in_center_x;
        cy_r     <= in_center_y;
        maj_r    <= OW'(in_radius);
        min_r    <= '0;
        dec_r    <= $signed(DW'(1)) - $signed(DW'(in_radius));
        filled_r <= in_fill_mode;
        color_r  <= in_color_in;
      end else begin
        a_cx_r    <= cx_r;
        a_cy_r    <= cy_r;
        a_x_r     <= maj_r;
        a_y_r     <= min_r;
        a_color_r <= color_r;
        a_flags_r <= flags_nxt;
        if (active_r && !zero_rad) begin
          maj_r <= x_nxt;
          min_r <= y_nxt;
          dec_r <= dec_nxt;
        end
      end
    end
  end

  assign a_valid = a_valid_r;
  assign a_cx    = a_cx_r;
  assign a_cy    = a_cy_r;
  assign a_x     = a_x_r;
  assign a_y     = a_y_r;
  assign a_color = a_color_r;
  assign a_flags = a_flags_r;

endmodule

// ===== src/mcr_eval.sv =====
// Evaluates the eight symmetric pixels or four spans of one step against the canvas.
module mcr_eval #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]  cx,
  input  logic signed [COORD_BITS-1:0]  cy,
  input  logic [RADIUS_BITS:0]          x,
  input  logic [RADIUS_BITS:0]          y,
  input  mcr_pkg::step_flags_t          flags,
  input  logic [mcr_pkg::CFG_W-1:0]     canvas_w,
  input  logic [mcr_pkg::CFG_W-1:0]     canvas_h,
  output mcr_pkg::cand_t                cand [mcr_pkg::NCAND],
  output logic [mcr_pkg::NCAND-1:0]     mask,
  output logic                          done
);

  localparam int OW = RADIUS_BITS + 1;
  localparam int MW = (COORD_BITS > OW) ? COORD_BITS : OW;
  localparam int SW = MW + 2;

  logic signed [SW-1:0] cxs, cys, xs, ys, ws, hs;
  logic signed [SW-1:0] col_px, col_mx, col_py, col_my;
  logic signed [SW-1:0] row_py, row_my, row_px, row_mx;
  mcr_pkg::cand_t       pix [mcr_pkg::NCAND];
  mcr_pkg::cand_t       spn [mcr_pkg::NCAND];
  logic [mcr_pkg::NCAND-1:0] vis;

  function automatic logic in_rng(input logic signed [SW-1:0] v,
                                  input logic signed [SW-1:0] lim);
    return !v[SW-1] && (v < lim);
  endfunction

  function automatic mcr_pkg::cand_t mk_pixel(input logic signed [SW-1:0] col,
                                              input logic signed [SW-1:0] row,
                                              input logic signed [SW-1:0] wl,
                                              input logic signed [SW-1:0] hl);
    mcr_pkg::cand_t c;
    c.x   = col[mcr_pkg::OUT_W-1:0];
    c.xe  = col[mcr_pkg::OUT_W-1:0];
    c.y   = row[mcr_pkg::OUT_W-1:0];
    c.vis = in_rng(col, wl) && in_rng(row, hl);
    return c;
  endfunction

  // Clamp the span to the canvas columns; it is dropped when empty afterwards.
  function automatic mcr_pkg::cand_t mk_span(input logic signed [SW-1:0] row,
                                             input logic signed [SW-1:0] c0,
                                             input logic signed [SW-1:0] c1,
                                             input logic signed [SW-1:0] wl,
                                             input logic signed [SW-1:0] hl);
    mcr_pkg::cand_t       c;
    logic signed [SW-1:0] x0, x1, wm1;
    wm1   = wl - $signed(SW'(1));
    x0    = c0[SW-1] ? '0 : c0;
    x1    = (c1 > wm1) ? wm1 : c1;
    c.x   = x0[mcr_pkg::OUT_W-1:0];
    c.xe  = x1[mcr_pkg::OUT_W-1:0];
    c.y   = row[mcr_pkg::OUT_W-1:0];
    c.vis = in_rng(row, hl) && (x0 <= x1);
    return c;
  endfunction

  always_comb begin
    cxs = SW'(cx);
    cys = SW'(cy);
    xs  = $signed(SW'(x));
    ys  = $signed(SW'(y));
    ws  = $signed(SW'(canvas_w));
    hs  = $signed(SW'(canvas_h));

    col_px = cxs + xs;
    col_mx = cxs - xs;
    col_py = cxs + ys;
    col_my = cxs - ys;
    row_py = cys + ys;
    row_my = cys - ys;
    row_px = cys + xs;
    row_mx = cys - xs;

    pix[0] = mk_pixel(col_px, row_py, ws, hs);
    pix[1] = mk_pixel(col_mx, row_py, ws, hs);
    pix[2] = mk_pixel(col_px, row_my, ws, hs);
    pix[3] = mk_pixel(col_mx, row_my, ws, hs);
    pix[4] = mk_pixel(col_py, row_px, ws, hs);
    pix[5] = mk_pixel(col_my, row_px, ws, hs);
    pix[6] = mk_pixel(col_py, row_mx, ws, hs);
    pix[7] = mk_pixel(col_my, row_mx, ws, hs);

    spn[0] = mk_span(row_py, col_mx, col_px, ws, hs);
    spn[1] = mk_span(row_my, col_mx, col_px, ws, hs);
    spn[2] = mk_span(row_px, col_my, col_py, ws, hs);
    spn[3] = mk_span(row_mx, col_my, col_py, ws, hs);
    for (int i = 4; i < mcr_pkg::NCAND; i++) begin
      spn[i] = '0;
    end

    for (int i = 0; i < mcr_pkg::NCAND; i++) begin
      cand[i] = flags.filled ? spn[i] : pix[i];
      vis[i]  = cand[i].vis;
    end

    if (flags.filled) begin
      vis[1] = vis[1] && flags.mirror_en;
      vis[3] = vis[3] && flags.diag_en;
    end
    // A zero radius plots the centre alone, which is the first candidate.
    if (flags.zero_radius) begin
      vis = vis & mcr_pkg::NCAND'(1);
    end

    mask = vis;
    if (flags.inactive || (vis == '0)) begin
      cand[0] = '0;
      mask    = mcr_pkg::NCAND'(1);
    end
    done = flags.done;
  end

endmodule

// ===== src/mcr_serial.sv =====
// Candidate buffer and output register that hand out one result item per cycle while the receiver is ready.
module mcr_serial (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          a_valid,
  output logic                          a_take,
  input  mcr_pkg::cand_t                cand [mcr_pkg::NCAND],
  input  logic [mcr_pkg::NCAND-1:0]     mask,
  input  logic [mcr_pkg::COLOR_W-1:0]   color,
  input  logic                          done,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mcr_pkg::OUT_W-1:0]     out_x,
  output logic [mcr_pkg::OUT_W-1:0]     out_x_end,
  output logic [mcr_pkg::OUT_W-1:0]     out_y,
  output logic [mcr_pkg::COLOR_W-1:0]   out_color_out,
  output logic                          out_visible,
  output logic                          out_last,
  output logic                          out_done_res
);

  localparam int IW = $clog2(mcr_pkg::NCAND);

  mcr_pkg::cand_t              cand_r [mcr_pkg::NCAND];
  logic [mcr_pkg::NCAND-1:0]   mask_r, rem;
  logic [mcr_pkg::COLOR_W-1:0] color_r;
  logic                        done_r, b_valid_r;
  logic [IW-1:0]               pick;
  logic                        out_load;

  logic                        out_valid_r, out_vis_r, out_last_r, out_done_r;
  logic [mcr_pkg::OUT_W-1:0]   out_x_r, out_xe_r, out_y_r;
  logic [mcr_pkg::COLOR_W-1:0] out_color_r;

  // Lowest pending candidate goes out first, which keeps the symmetric order.
  always_comb begin
    pick = '0;
    for (int i = mcr_pkg::NCAND - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = IW'(i);
      end
    end
    rem       = mask_r;
    rem[pick] = 1'b0;
  end

  assign out_load = b_valid_r && (!out_valid_r || out_ready);
  assign a_take   = !b_valid_r || (out_load && (rem == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_take) begin
        b_valid_r <= a_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take && a_valid) begin
      cand_r  <= cand;
      mask_r  <= mask;
      color_r <= color;
      done_r  <= done;
    end else if (out_load) begin
      mask_r <= rem;
    end
    if (out_load) begin
      out_x_r     <= cand_r[pick].x;
      out_xe_r    <= cand_r[pick].xe;
      out_y_r     <= cand_r[pick].y;
      out_vis_r   <= cand_r[pick].vis;
      out_color_r <= color_r;
      out_last_r  <= (rem == '0);
      out_done_r  <= done_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_x_end     = out_xe_r;
  assign out_y         = out_y_r;
  assign out_color_out = out_color_r;
  assign out_visible   = out_vis_r;
  assign out_last      = out_last_r;
  assign out_done_res  = out_done_r;

endmodule

// ===== src/midpoint_circle_rasterizer_top.sv =====
// Top level of the midpoint circle rasterizer.
//
// Input channel (in_valid/in_ready): a load item (in_cmd = 0) stores a circle's
// centre, radius, fill mode and colour and gives no result. Each step item
// (in_cmd = 1) runs one row of the midpoint loop and gives one to eight result
// items on the output channel (out_valid/out_ready): outline pixels or clamped
// filled spans, the final one flagged by out_last. A step with nothing on the
// canvas gives a single item with out_visible low.
// A step passes the step snapshot, the candidate buffer and the output register
// before its first result appears. Results leave at one result item per cycle
// while the receiver is ready; the output register and the candidate buffer set
// this rate. A load may be accepted while earlier results are still draining.
// Configuration (cfg_we/cfg_index/cfg_data) sets the canvas size; the user is to
// write it while the block is idle, which the block itself does not enforce;
// values above 4096 act as 4096.
// Reset (rst_n, synchronous) restores an 800 by 600 canvas and unloads the
// circle. When the receiver stalls, the output item holds and the step snapshot
// and the candidate buffer fill before in_ready falls.
module midpoint_circle_rasterizer_top #(
  parameter int RADIUS_BITS = mcr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcr_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic signed [COORD_BITS-1:0]    in_center_x,
  input  logic signed [COORD_BITS-1:0]    in_center_y,
  input  logic [RADIUS_BITS-1:0]          in_radius,
  input  logic                            in_fill_mode,
  input  logic [mcr_pkg::COLOR_W-1:0]     in_color_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcr_pkg::OUT_W-1:0]       out_x,
  output logic [mcr_pkg::OUT_W-1:0]       out_x_end,
  output logic [mcr_pkg::OUT_W-1:0]       out_y,
  output logic [mcr_pkg::COLOR_W-1:0]     out_color_out,
  output logic                            out_visible,
  output logic                            out_last,
  output logic                            out_done_res
);

  logic                         a_valid, a_take, done;
  logic signed [COORD_BITS-1:0] a_cx, a_cy;
  logic [RADIUS_BITS:0]         a_x, a_y;
  logic [mcr_pkg::COLOR_W-1:0]  a_color;
  mcr_pkg::step_flags_t         a_flags;
  logic [mcr_pkg::CFG_W-1:0]    canvas_w, canvas_h;
  mcr_pkg::cand_t               cand [mcr_pkg::NCAND];
  logic [mcr_pkg::NCAND-1:0]    mask;

  mcr_state #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_radius    (in_radius),
    .in_fill_mode (in_fill_mode),
    .in_color_in  (in_color_in),
    .a_take       (a_take),
    .a_valid      (a_valid),
    .a_cx         (a_cx),
    .a_cy         (a_cy),
    .a_x          (a_x),
    .a_y          (a_y),
    .a_color      (a_color),
    .a_flags      (a_flags),
    .canvas_w     (canvas_w),
    .canvas_h     (canvas_h)
  );

  mcr_eval #(
    .RADIUS_BITS (RADIUS_BITS),
    .COORD_BITS  (COORD_BITS)
  ) u_eval (
    .cx       (a_cx),
    .cy       (a_cy),
    .x        (a_x),
    .y        (a_y),
    .flags    (a_flags),
    .canvas_w (canvas_w),
    .canvas_h (canvas_h),
    .cand     (cand),
    .mask     (mask),
    .done     (done)
  );

  mcr_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .a_valid       (a_valid),
    .a_take        (a_take),
    .cand          (cand),
    .mask          (mask),
    .color         (a_color),
    .done          (done),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_x         (out_x),
    .out_x_end     (out_x_end),
    .out_y         (out_y),
    .out_color_out (out_color_out),
    .out_visible   (out_visible),
    .out_last      (out_last),
    .out_done_res  (out_done_res)
  );

endmodule

// ===== src/mcr_checker.sv =====
// Port-level assertion checker for the midpoint circle rasterizer, bound to the top level.
`include "midpoint_circle_rasterizer_top_defines.svh"

module mcr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mcr_pkg::OUT_W-1:0]     out_x,
  input logic [mcr_pkg::OUT_W-1:0]     out_x_end,
  input logic [mcr_pkg::OUT_W-1:0]     out_y,
  input logic [mcr_pkg::COLOR_W-1:0]   out_color_out,
  input logic                          out_visible,
  input logic                          out_last,
  input logic                          out_done_res
);

  // A stalled result item holds every field.
  `MCR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_x_end) && $stable(out_y) && $stable(out_color_out) && $stable(out_visible) && $stable(out_last) && $stable(out_done_res), "result item changed while stalled")

  // An invisible item is only ever the sole item of its step.
  `MCR_ASSERT_NOW(a_invis_last, out_valid && !out_visible, out_last, "invisible item is not the last of its step")

  // Clamped spans never run backwards; outline pixels have equal ends.
  `MCR_ASSERT_NOW(a_span_order, out_valid && out_visible, out_x <= out_x_end, "span ends out of order")

  // The rest of a step follows without a gap once an item is taken.
  `MCR_ASSERT_NEXT(a_step_burst, out_valid && out_ready && !out_last, out_valid, "gap inside the results of a step")

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (.*);

// ===== verif/midpoint_circle_rasterizer_top_test.sv =====
// Self-checking testbench for the midpoint circle rasterizer top level.
`timescale 1ns / 1ps

module midpoint_circle_rasterizer_top_test;

  typedef struct {
    logic              cmd;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [9:0]        radius;
    logic              fill;
    logic [mcr_pkg::COLOR_W-1:0] color;
  } circle_cmd_t;

  typedef struct {
    logic [mcr_pkg::OUT_W-1:0]   x;
    logic [mcr_pkg::OUT_W-1:0]   x_end;
    logic [mcr_pkg::OUT_W-1:0]   y;
    logic [mcr_pkg::COLOR_W-1:0] color;
    logic               visible;
    logic               last;
    logic               done;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index = mcr_pkg::REG_CANVAS_WIDTH;
  logic [mcr_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_cmd = mcr_pkg::CMD_LOAD;
  logic signed [15:0] in_center_x = '0;
  logic signed [15:0] in_center_y = '0;
  logic [9:0] in_radius = '0;
  logic in_fill_mode = 1'b0;
  logic [mcr_pkg::COLOR_W-1:0] in_color_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [mcr_pkg::OUT_W-1:0] out_x;
  logic [mcr_pkg::OUT_W-1:0] out_x_end;
  logic [mcr_pkg::OUT_W-1:0] out_y;
  logic [mcr_pkg::COLOR_W-1:0] out_color_out;
  logic out_visible;
  logic out_last;
  logic out_done_res;

  midpoint_circle_rasterizer_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_center_x(in_center_x), .in_center_y(in_center_y), .in_radius(in_radius),
    .in_fill_mode(in_fill_mode), .in_color_in(in_color_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_x(out_x), .out_x_end(out_x_end),
    .out_y(out_y), .out_color_out(out_color_out), .out_visible(out_visible),
    .out_last(out_last), .out_done_res(out_done_res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  circle_cmd_t queued_cmds[$];
  pixel_t      expected_pixels[$];
  pixel_t      step_pixels[$];

  // Shadow of the rasterizer state and canvas registers.
  int               ctr_col, ctr_row, major_off, minor_off, decision_var;
  logic             fill_on;
  logic [mcr_pkg::COLOR_W-1:0] shade;
  logic             circle_live;
  logic [mcr_pkg::CFG_W-1:0] canvas_w_reg = mcr_pkg::CANVAS_W_RESET;
  logic [mcr_pkg::CFG_W-1:0] canvas_h_reg = mcr_pkg::CANVAS_H_RESET;

  int mismatches = 0;
  int loads_seen = 0;
  int steps_seen = 0;
  int results_checked = 0;
  int visible_seen = 0;
  int stall_requests = 0;
  int stall_seen = 0;
  bit calm = 1'b0;

  function automatic int clip_dim(logic [mcr_pkg::CFG_W-1:0] d);
    return (d > mcr_pkg::CANVAS_MAX) ? int'(mcr_pkg::CANVAS_MAX) : int'(d);
  endfunction

  function automatic void add_pixel(int px, int pxe, int py, logic vis);
    pixel_t p;
    p.x = px[mcr_pkg::OUT_W-1:0];
    p.x_end = pxe[mcr_pkg::OUT_W-1:0];
    p.y = py[mcr_pkg::OUT_W-1:0];
    p.color = shade;
    p.visible = vis;
    p.last = 1'b0;
    p.done = 1'b0;
    step_pixels.push_back(p);
  endfunction

  function automatic void plot_pixel(int px, int py);
    if (px < 0 || px >= clip_dim(canvas_w_reg) || py < 0 || py >= clip_dim(canvas_h_reg))
      return;
    add_pixel(px, px, py, 1'b1);
  endfunction

  function automatic void fill_span(int sy, int sx0, int sx1);
    int w;
    w = clip_dim(canvas_w_reg);
    if (sy < 0 || sy >= clip_dim(canvas_h_reg))
      return;
    if (sx0 < 0)
      sx0 = 0;
    if (sx1 > w - 1)
      sx1 = w - 1;
    if (sx0 > sx1)
      return;
    add_pixel(sx0, sx1, sy, 1'b1);
  endfunction

  // Works out the result items of one accepted item and queues them.
  function automatic void rasterize_item(circle_cmd_t c);
    int x, y;
    step_pixels.delete();
    if (c.cmd == mcr_pkg::CMD_LOAD) begin
      ctr_col = c.cx;
      ctr_row = c.cy;
      major_off = c.radius;
      minor_off = 0;
      decision_var = 1 - major_off;
      fill_on = c.fill;
      shade = c.color;
      circle_live = 1'b1;
      loads_seen++;
      return;
    end
    steps_seen++;
    if (circle_live) begin
      x = major_off;
      y = minor_off;
      if (x == 0 && y == 0) begin
        if (fill_on)
          fill_span(ctr_row, ctr_col, ctr_col);
        else
          plot_pixel(ctr_col, ctr_row);
        circle_live = 1'b0;
      end else begin
        if (fill_on) begin
          fill_span(ctr_row + y, ctr_col - x, ctr_col + x);
          if (y != 0)
            fill_span(ctr_row - y, ctr_col - x, ctr_col + x);
          fill_span(ctr_row + x, ctr_col - y, ctr_col + y);
          if (x != y)
            fill_span(ctr_row - x, ctr_col - y, ctr_col + y);
        end else begin
          plot_pixel(ctr_col + x, ctr_row + y);
          plot_pixel(ctr_col - x, ctr_row + y);
          plot_pixel(ctr_col + x, ctr_row - y);
          plot_pixel(ctr_col - x, ctr_row - y);
          plot_pixel(ctr_col + y, ctr_row + x);
          plot_pixel(ctr_col - y, ctr_row + x);
          plot_pixel(ctr_col + y, ctr_row - x);
          plot_pixel(ctr_col - y, ctr_row - x);
        end
        y++;
        if (decision_var <= 0) begin
          decision_var += 2 * y + 1;
        end else begin
          x--;
          decision_var += 2 * (y - x) + 1;
        end
        major_off = x;
        minor_off = y;
        if (x < y)
          circle_live = 1'b0;
      end
    end
    // A step with nothing on the canvas, or with no circle, still gives one item.
    if (step_pixels.size() == 0)
      add_pixel(0, 0, 0, 1'b0);
    foreach (step_pixels[k]) begin
      step_pixels[k].done = !circle_live;
      step_pixels[k].last = (k == step_pixels.size() - 1);
      expected_pixels.push_back(step_pixels[k]);
    end
  endfunction

  circle_cmd_t seen_cmd;

  always @(posedge clk) begin
    if (!rst_n) begin
      ctr_col = 0;
      ctr_row = 0;
      major_off = 0;
      minor_off = 0;
      decision_var = 0;
      fill_on = 1'b0;
      shade = '0;
      circle_live = 1'b0;
      canvas_w_reg = mcr_pkg::CANVAS_W_RESET;
      canvas_h_reg = mcr_pkg::CANVAS_H_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mcr_pkg::REG_CANVAS_WIDTH)
          canvas_w_reg = cfg_data;
        else
          canvas_h_reg = cfg_data;
      end
      if (in_valid && in_ready) begin
        seen_cmd.cmd = in_cmd;
        seen_cmd.cx = in_center_x;
        seen_cmd.cy = in_center_y;
        seen_cmd.radius = in_radius;
        seen_cmd.fill = in_fill_mode;
        seen_cmd.color = in_color_in;
        rasterize_item(seen_cmd);
      end
    end
  end

  // Driver: presents queued items, with random gaps between them.
  circle_cmd_t drive_cmd;
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        drive_cmd = queued_cmds.pop_front();
        in_valid <= 1'b1;
        in_cmd <= drive_cmd.cmd;
        in_center_x <= drive_cmd.cx;
        in_center_y <= drive_cmd.cy;
        in_radius <= drive_cmd.radius;
        in_fill_mode <= drive_cmd.fill;
        in_color_in <= drive_cmd.color;
        if (!calm && $urandom_range(0, 5) == 0)
          send_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
    end else if (stall_seen != stall_requests) begin
      stall_seen <= stall_requests;
      hold_cnt <= 80;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(1, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  pixel_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result item with none expected: x %0d y %0d", out_x, out_y);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("out_x", 32'(want.x), 32'(out_x));
        check_field("out_x_end", 32'(want.x_end), 32'(out_x_end));
        check_field("out_y", 32'(want.y), 32'(out_y));
        check_field("out_color_out", 32'(want.color), 32'(out_color_out));
        check_field("out_visible", 32'(want.visible), 32'(out_visible));
        check_field("out_last", 32'(want.last), 32'(out_last));
        check_field("out_done_res", 32'(want.done), 32'(out_done_res));
        results_checked++;
        if (out_visible)
          visible_seen++;
      end
    end
  end

  function automatic circle_cmd_t make_cmd(logic cmd, int cx, int cy, int r, logic fill,
                                           int color);
    circle_cmd_t c;
    c.cmd = cmd;
    c.cx = cx[15:0];
    c.cy = cy[15:0];
    c.radius = r[9:0];
    c.fill = fill;
    c.color = color[mcr_pkg::COLOR_W-1:0];
    return c;
  endfunction

  // Step items carry random payloads, which the block should ignore.
  function automatic void queue_circle(int cx, int cy, int r, logic fill, int color,
                                       int n_steps);
    queued_cmds.push_back(make_cmd(mcr_pkg::CMD_LOAD, cx, cy, r, fill, color));
    repeat (n_steps)
      queued_cmds.push_back(make_cmd(mcr_pkg::CMD_STEP, $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 1023),
                                     1'($urandom_range(0, 1)), $urandom_range(0, 'hFFFFFF)));
  endfunction

  // Mostly whole circles of small radius near the canvas; some cut short, some noise.
  function automatic void queue_random(int budget, int w, int h);
    int pushed, r, cx, cy, n, full, pick;
    pushed = 0;
    if (w > 4096)
      w = 4096;
    if (h > 4096)
      h = 4096;
    while (pushed < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        queued_cmds.push_back(make_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                                       $urandom_range(0, 65535), $urandom_range(0, 1023),
                                       1'($urandom_range(0, 1)),
                                       $urandom_range(0, 'hFFFFFF)));
        pushed++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 75)
          r = $urandom_range(0, 12);
        else if (pick < 95)
          r = $urandom_range(13, 60);
        else
          r = $urandom_range(61, 1023);
        if ($urandom_range(0, 99) < 85) begin
          cx = int'($urandom_range(0, w + 2 * r + 8)) - r - 4;
          cy = int'($urandom_range(0, h + 2 * r + 8)) - r - 4;
        end else begin
          cx = $urandom_range(0, 65535);
          cy = $urandom_range(0, 65535);
        end
        full = r * 707 / 1000 + 2;
        if (r > 60)
          n = $urandom_range(1, 12);
        else if ($urandom_range(0, 9) == 0)
          n = $urandom_range(0, full);
        else
          n = full + $urandom_range(0, 1);
        queue_circle(cx, cy, r, 1'($urandom_range(0, 1)), $urandom_range(0, 'hFFFFFF), n);
        pushed += n + 1;
      end
    end
  endfunction

  // Loads give no result, so the task goes on waiting after the queues drain.
  task automatic wait_drained();
    do
      @(negedge clk);
    while (queued_cmds.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_canvas(int w, int h);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= mcr_pkg::REG_CANVAS_WIDTH;
    cfg_data <= w[mcr_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_index <= mcr_pkg::REG_CANVAS_HEIGHT;
    cfg_data <= h[mcr_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items on the reset canvas.
    queued_cmds.push_back(make_cmd(mcr_pkg::CMD_STEP, 0, 0, 0, 1'b0, 0));
    queue_circle(5, 5, 0, 1'b0, 'h123456, 2);
    queue_circle(-1, 3, 0, 1'b1, 'hABCDEF, 1);
    queue_circle(0, 0, 1, 1'b0, 'hFFFFFF, 2);
    queue_circle(799, 599, 3, 1'b1, 'h000000, 3);
    queue_circle(32767, -32768, 1023, 1'b0, 'hFFFFFF, 2);
    queue_circle(-32768, 32767, 1023, 1'b1, 'h000000, 1);
    queue_circle(400, 300, 2, 1'b1, 'h00FF00, 3);
    queue_random(60, 800, 600);
    wait_drained();

    write_canvas(4096, 4096);
    queue_random(70, 4096, 4096);
    stall_requests++;
    wait_drained();

    write_canvas(1, 1);
    queue_random(30, 1, 1);
    wait_drained();

    // A zero width clips everything; an oversized height acts as the largest one.
    write_canvas(0, 8191);
    queue_random(25, 0, 8191);
    wait_drained();

    write_canvas(320, 240);
    calm = 1'b1;
    queue_random(65, 320, 240);
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d circle loads and %0d row steps on five canvas sizes.",
             loads_seen, steps_seen);
    $display("Checked %0d result items, %0d of them visible.", results_checked, visible_seen);
    if (mismatches == 0)
      $display("midpoint_circle_rasterizer_top_test OK");
    else
      $display("midpoint_circle_rasterizer_top_test NOT OK");
    $finish;
  end

  initial begin
    #3000000;
    $display("midpoint_circle_rasterizer_top_test NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/mcr_pkg.sv
src/mcr_state.sv
src/mcr_eval.sv
src/mcr_serial.sv
src/midpoint_circle_rasterizer_top.sv
src/mcr_checker.sv
verif/midpoint_circle_rasterizer_top_test.sv
